FILE: sv/pvc_pkg.sv
`timescale 1ns / 1ps
package pvc_pkg;
    localparam int MAX_LEN = 64;
    localparam int IDX_W = $clog2(MAX_LEN);
    localparam int LEN_W = IDX_W + 1;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [1:0] ORD_LT = 2'b11;
    localparam logic [1:0] ORD_EQ = 2'b00;
    localparam logic [1:0] ORD_GT = 2'b01;

    typedef logic [9:0] rank_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    // tilde lowest, end of run next (rank 1), letters, then the rest
    function automatic rank_t rank_of(input logic [7:0] c);
        if (c == CH_TILDE) return 10'd0;
        if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A))
            return {2'b00, c};
        return {2'b01, c};
    endfunction
endpackage

FILE: sv/package_version_comparator_unit.sv
`timescale 1ns / 1ps
// Package version comparator.
// Slave channel: one word per cycle while tready is high, tdata =
// {char_valid, ch}, tuser = which_string (0 = A, 1 = B), tlast ends
// that string. Words for a string already ended are dropped while the
// other string is open. Characters past MAX_LEN are dropped and flagged
// in the result. Once both strings end, s_axis_tready falls and a
// sequencer scans the buffers with one shared compare unit. Each step
// reads one registered buffer entry per string, waits for the read, then
// compares. Splitting scans each string for its colon and then its last
// dash before the runs are compared. No new string is taken until the
// result has been sent.
// Master channel: tdata = {too_long, order}, order signed 2 bits. The result
// waits in the output register until taken; the block then clears its
// lengths and flags and raises tready again in the next cycle.
// Reset (synchronous, active low) empties both strings; buffer contents are
// not cleared.
module package_version_comparator_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [7:0] ch, [8] char_valid
    input  logic       s_axis_tuser,   // [0] which_string
    input  logic       s_axis_tlast,   // last
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [1:0] order, [2] too_long
);
    import pvc_pkg::*;

    typedef enum logic [3:0] {
        S_LOAD, S_SPLIT_A, S_SPLIT_B, S_PART, S_NONDIG, S_ZERO,
        S_CNT, S_DIGCMP, S_OUT
    } state_t;

    logic [7:0] buf_a [MAX_LEN];
    logic [7:0] buf_b [MAX_LEN];

    state_t state_reg;
    logic [LEN_W-1:0] len_a_reg, len_b_reg;
    logic done_a_reg, done_b_reg, ovf_reg;
    // split bounds: epoch end, upstream start, dash position per string
    logic [LEN_W-1:0] ea_reg, ra_reg, da_reg, eb_reg, rb_reg, db_reg;
    logic [LEN_W-1:0] k_reg;       // split scan index
    logic [1:0] phase_reg;         // split sub-phase
    logic digits_reg;
    logic [1:0] part_reg;
    logic [LEN_W-1:0] ai_reg, ae_reg, bi_reg, be_reg;
    logic [LEN_W-1:0] cnta_reg, cntb_reg;
    logic [1:0] order_reg;
    logic rd_ok_reg;               // buffer read data matches the pointers

    logic sel;
    logic [7:0] chv;
    assign sel = s_axis_tuser;
    assign chv = s_axis_tdata[7:0];
    assign s_axis_tready = (state_reg == S_LOAD);
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata = {5'd0, ovf_reg, order_reg};

    logic acc;
    logic sel_done;
    assign acc = s_axis_tvalid && s_axis_tready;
    assign sel_done = sel ? done_b_reg : done_a_reg;

    // shared unit address: one character from each buffer per step
    logic [LEN_W-1:0] pa, pb;
    logic [7:0] ca_reg, cb_reg;
    logic ha, hb;
    always_comb begin
        pa = ai_reg + cnta_reg;
        pb = bi_reg + cntb_reg;
        if (state_reg == S_SPLIT_A) pa = k_reg;
        if (state_reg == S_SPLIT_B) pb = k_reg;
        if (state_reg == S_DIGCMP) begin
            pa = ai_reg;
            pb = bi_reg;
        end
    end

    // memory write at load, registered read for the sequencer
    always_ff @(posedge aclk) begin
        ca_reg <= buf_a[pa[IDX_W-1:0]];
        cb_reg <= buf_b[pb[IDX_W-1:0]];
        if (acc && !sel_done && s_axis_tdata[8]) begin
            if (!sel && len_a_reg < LEN_W'(MAX_LEN)) buf_a[len_a_reg[IDX_W-1:0]] <= chv;
            if (sel && len_b_reg < LEN_W'(MAX_LEN)) buf_b[len_b_reg[IDX_W-1:0]] <= chv;
        end
    end

    logic need_rd;
    assign need_rd = (state_reg != S_LOAD) && (state_reg != S_PART) &&
                     (state_reg != S_OUT);

    logic [LEN_W-1:0] slen;
    logic [7:0] sc;
    assign slen = (state_reg == S_SPLIT_A) ? len_a_reg : len_b_reg;
    assign sc = (state_reg == S_SPLIT_A) ? ca_reg : cb_reg;

    rank_t rka, rkb;
    always_comb begin
        ha = (ai_reg < ae_reg) && !is_digit(ca_reg);
        hb = (bi_reg < be_reg) && !is_digit(cb_reg);
        rka = ha ? rank_of(ca_reg) : 10'd1;
        rkb = hb ? rank_of(cb_reg) : 10'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
            len_a_reg <= '0; len_b_reg <= '0;
            done_a_reg <= 1'b0; done_b_reg <= 1'b0; ovf_reg <= 1'b0;
            rd_ok_reg <= 1'b0;
        end else if (need_rd && !rd_ok_reg) begin
            // wait for the registered buffer read
            rd_ok_reg <= 1'b1;
        end else begin
            rd_ok_reg <= 1'b0;
            unique case (state_reg)
                S_LOAD: begin
                    // take a word into the selected buffer
                    if (acc && !sel_done) begin
                        if (s_axis_tdata[8]) begin
                            if (!sel) begin
                                if (len_a_reg < LEN_W'(MAX_LEN)) len_a_reg <= len_a_reg + 1'b1;
                                else ovf_reg <= 1'b1;
                            end else begin
                                if (len_b_reg < LEN_W'(MAX_LEN)) len_b_reg <= len_b_reg + 1'b1;
                                else ovf_reg <= 1'b1;
                            end
                        end
                        if (s_axis_tlast) begin
                            if (!sel) done_a_reg <= 1'b1; else done_b_reg <= 1'b1;
                            if ((sel ? done_a_reg : done_b_reg)) begin
                                state_reg <= S_SPLIT_A;
                                k_reg <= '0; phase_reg <= 2'd0;
                                digits_reg <= 1'b1;
                            end
                        end
                    end
                end
                S_SPLIT_A, S_SPLIT_B: begin
                    // phase 0: find colon, phase 1: find last dash
                    if (phase_reg == 2'd0) begin
                        if (k_reg >= slen || sc == CH_COLON) begin
                            if (k_reg < slen && k_reg != '0 && digits_reg) begin
                                if (state_reg == S_SPLIT_A) begin
                                    ea_reg <= k_reg; ra_reg <= k_reg + 1'b1;
                                end else begin
                                    eb_reg <= k_reg; rb_reg <= k_reg + 1'b1;
                                end
                                k_reg <= k_reg + 1'b1;
                            end else begin
                                if (state_reg == S_SPLIT_A) begin
                                    ea_reg <= '0; ra_reg <= '0;
                                end else begin
                                    eb_reg <= '0; rb_reg <= '0;
                                end
                                k_reg <= '0;
                            end
                            if (state_reg == S_SPLIT_A) da_reg <= len_a_reg;
                            else db_reg <= len_b_reg;
                            phase_reg <= 2'd1;
                        end else begin
                            if (!is_digit(sc)) digits_reg <= 1'b0;
                            k_reg <= k_reg + 1'b1;
                        end
                    end else begin
                        if (k_reg >= slen) begin
                            k_reg <= '0; phase_reg <= 2'd0; digits_reg <= 1'b1;
                            if (state_reg == S_SPLIT_A) state_reg <= S_SPLIT_B;
                            else begin
                                state_reg <= S_PART; part_reg <= 2'd0;
                            end
                        end else begin
                            if (sc == CH_DASH) begin
                                if (state_reg == S_SPLIT_A) da_reg <= k_reg;
                                else db_reg <= k_reg;
                            end
                            k_reg <= k_reg + 1'b1;
                        end
                    end
                end
                S_PART: begin
                    // load bounds of the next part or finish equal
                    cnta_reg <= '0; cntb_reg <= '0;
                    unique case (part_reg)
                        2'd0: begin
                            ai_reg <= '0; ae_reg <= ea_reg;
                            bi_reg <= '0; be_reg <= eb_reg;
                            state_reg <= S_NONDIG;
                        end
                        2'd1: begin
                            ai_reg <= ra_reg; ae_reg <= da_reg;
                            bi_reg <= rb_reg; be_reg <= db_reg;
                            state_reg <= S_NONDIG;
                        end
                        2'd2: begin
                            ai_reg <= (da_reg < len_a_reg) ? da_reg + 1'b1 : len_a_reg;
                            ae_reg <= len_a_reg;
                            bi_reg <= (db_reg < len_b_reg) ? db_reg + 1'b1 : len_b_reg;
                            be_reg <= len_b_reg;
                            state_reg <= S_NONDIG;
                        end
                        default: begin
                            order_reg <= ORD_EQ;
                            state_reg <= S_OUT;
                        end
                    endcase
                    part_reg <= part_reg + 1'b1;
                end
                S_NONDIG: begin
                    // compare non-digit run a character pair at a time
                    if (ai_reg >= ae_reg && bi_reg >= be_reg) begin
                        state_reg <= S_PART;
                    end else if (!ha && !hb) begin
                        state_reg <= S_ZERO;
                    end else if (rka != rkb) begin
                        order_reg <= (rka < rkb) ? ORD_LT : ORD_GT;
                        state_reg <= S_OUT;
                    end else begin
                        if (ha) ai_reg <= ai_reg + 1'b1;
                        if (hb) bi_reg <= bi_reg + 1'b1;
                    end
                end
                S_ZERO: begin
                    // skip leading zeros on both sides
                    logic za, zb;
                    za = (ai_reg < ae_reg) && ca_reg == CH_ZERO;
                    zb = (bi_reg < be_reg) && cb_reg == CH_ZERO;
                    if (za) ai_reg <= ai_reg + 1'b1;
                    if (zb) bi_reg <= bi_reg + 1'b1;
                    if (!za && !zb) state_reg <= S_CNT;
                end
                S_CNT: begin
                    // measure digit run lengths
                    logic ga, gb;
                    ga = (pa < ae_reg) && is_digit(ca_reg);
                    gb = (pb < be_reg) && is_digit(cb_reg);
                    if (ga) cnta_reg <= cnta_reg + 1'b1;
                    if (gb) cntb_reg <= cntb_reg + 1'b1;
                    if (!ga && !gb) begin
                        if (cnta_reg != cntb_reg) begin
                            order_reg <= (cnta_reg < cntb_reg) ? ORD_LT : ORD_GT;
                            state_reg <= S_OUT;
                        end else state_reg <= S_DIGCMP;
                    end
                end
                S_DIGCMP: begin
                    // equal lengths: compare digit by digit
                    if (cnta_reg == '0) begin
                        state_reg <= (ai_reg >= ae_reg && bi_reg >= be_reg) ? S_PART : S_NONDIG;
                    end else if (ca_reg != cb_reg) begin
                        order_reg <= (ca_reg < cb_reg) ? ORD_LT : ORD_GT;
                        state_reg <= S_OUT;
                    end else begin
                        ai_reg <= ai_reg + 1'b1; bi_reg <= bi_reg + 1'b1;
                        cnta_reg <= cnta_reg - 1'b1; cntb_reg <= cntb_reg - 1'b1;
                    end
                end
                S_OUT: begin
                    // hold result until taken, then clear
                    if (m_axis_tready) begin
                        state_reg <= S_LOAD;
                        len_a_reg <= '0; len_b_reg <= '0;
                        done_a_reg <= 1'b0; done_b_reg <= 1'b0; ovf_reg <= 1'b0;
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

    // lengths stay in range, the result word is well formed and held
    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        len_a_reg <= LEN_W'(MAX_LEN) && len_b_reg <= LEN_W'(MAX_LEN)) else $error("len");
    a_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> done_a_reg && done_b_reg) else $error("out");
    a_ord: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> order_reg != 2'b10) else $error("ord");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata)) else $error("hold");
endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
module tb;
    import pvc_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;

    package_version_comparator_unit dut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    typedef struct packed {
        logic       sel;
        logic [7:0] ch;
        logic       cv;
        logic       last;
    } char_word_t;

    typedef struct packed {
        logic [1:0] order;
        logic       too_long;
    } verdict_t;

    // predictor state
    logic [7:0] str_a [MAX_LEN];
    logic [7:0] str_b [MAX_LEN];
    int         len_a, len_b;
    bit         fin_a, fin_b, ovf;

    verdict_t   verdict_q [$];
    int         errors = 0;
    int         words_sent = 0;
    int         verdicts_seen = 0;
    bit         quiet = 1'b0;

    function automatic bit digit(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic int weight(logic [7:0] c);
        if (c == CH_TILDE) return -1;
        if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) return int'(c);
        return int'(c) + 256;
    endfunction

    function automatic int run_order(int ai, int ae, int bi, int be);
        int da, db, ra, rb;
        bit ha, hb;
        while (ai < ae || bi < be) begin
            forever begin
                ha = ai < ae && !digit(str_a[ai]);
                hb = bi < be && !digit(str_b[bi]);
                if (!ha && !hb) break;
                ra = ha ? weight(str_a[ai]) : 0;
                rb = hb ? weight(str_b[bi]) : 0;
                if (ra != rb) return ra < rb ? -1 : 1;
                if (ha) ai++;
                if (hb) bi++;
            end
            while (ai < ae && str_a[ai] == CH_ZERO) ai++;
            while (bi < be && str_b[bi] == CH_ZERO) bi++;
            da = 0;
            db = 0;
            while (ai + da < ae && digit(str_a[ai + da])) da++;
            while (bi + db < be && digit(str_b[bi + db])) db++;
            if (da != db) return da < db ? -1 : 1;
            for (int k = 0; k < da; k++)
                if (str_a[ai + k] != str_b[bi + k])
                    return str_a[ai + k] < str_b[bi + k] ? -1 : 1;
            ai += da;
            bi += db;
        end
        return 0;
    endfunction

    // bounds: epoch start/end, upstream start/end, revision start/end
    function automatic void split_parts(bit b_side, output int p [6]);
        int n, colon, dash, rest;
        bit alldig;
        logic [7:0] c;
        n = b_side ? len_b : len_a;
        colon = n;
        dash = n;
        rest = 0;
        alldig = 1'b1;
        p[0] = 0;
        p[1] = 0;
        for (int k = n - 1; k >= 0; k--) begin
            c = b_side ? str_b[k] : str_a[k];
            if (c == CH_COLON) colon = k;
        end
        if (colon < n && colon > 0) begin
            for (int k = 0; k < colon; k++) begin
                c = b_side ? str_b[k] : str_a[k];
                if (!digit(c)) alldig = 1'b0;
            end
            if (alldig) begin
                p[1] = colon;
                rest = colon + 1;
            end
        end
        for (int k = rest; k < n; k++) begin
            c = b_side ? str_b[k] : str_a[k];
            if (c == CH_DASH) dash = k;
        end
        p[2] = rest;
        p[3] = dash;
        p[4] = dash < n ? dash + 1 : n;
        p[5] = n;
    endfunction

    function automatic void clear_strings();
        len_a = 0;
        len_b = 0;
        fin_a = 0;
        fin_b = 0;
        ovf = 0;
    endfunction

    // advance the predictor by one accepted word
    function automatic void absorb_word(char_word_t w);
        int pa [6], pb [6], r;
        verdict_t v;
        if (w.sel ? fin_b : fin_a) return;
        if (w.cv) begin
            if (w.sel) begin
                if (len_b < MAX_LEN) str_b[len_b++] = w.ch;
                else ovf = 1;
            end else begin
                if (len_a < MAX_LEN) str_a[len_a++] = w.ch;
                else ovf = 1;
            end
        end
        if (w.last) begin
            if (w.sel) fin_b = 1;
            else fin_a = 1;
        end
        if (!(fin_a && fin_b)) return;
        split_parts(0, pa);
        split_parts(1, pb);
        r = 0;
        for (int part = 0; part < 3 && r == 0; part++)
            r = run_order(pa[2*part], pa[2*part+1], pb[2*part], pb[2*part+1]);
        v.order = r < 0 ? ORD_LT : (r > 0 ? ORD_GT : ORD_EQ);
        v.too_long = ovf;
        verdict_q.insert(verdict_q.size(), v);
        clear_strings();
    endfunction

    // drive one word, hold until taken
    task automatic send_word(char_word_t w);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, w.cv, w.ch};
        s_axis_tuser  <= w.sel;
        s_axis_tlast  <= w.last;
        do @(posedge aclk); while (!s_axis_tready);
        absorb_word(w);
        words_sent++;
    endtask

    task automatic send_string(bit sel, string s);
        char_word_t w;
        if (s.len() == 0) begin
            w = '{sel, 8'h00, 1'b0, 1'b1};
            send_word(w);
        end
        for (int k = 0; k < s.len(); k++) begin
            w = '{sel, s[k], 1'b1, k == s.len() - 1};
            send_word(w);
        end
    endtask

    // random string built from version-like pieces
    function automatic string rand_version();
        string s, pool;
        int n;
        pool = "0123456789~:-.+aZ";
        s = "";
        if ($urandom_range(0, 2) == 0) s = $sformatf("%0d:", $urandom_range(0, 12));
        n = $urandom_range(0, 10);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 15) == 0) s = {s, string'(byte'($urandom_range(1, 255)))};
            else s = {s, string'(pool[$urandom_range(0, pool.len() - 1)])};
        end
        if ($urandom_range(0, 1)) s = {s, $sformatf("-%0d", $urandom_range(0, 20))};
        return s;
    endfunction

    // receiver: random stall bursts, compare against oldest expectation
    initial begin
        verdict_t got, exp_v;
        int stall;
        @(posedge aresetn);
        forever begin
            if (!quiet && $urandom_range(0, 3) == 0) begin
                stall = $urandom_range(1, 16);
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            @(posedge aclk);
            if (m_axis_tvalid && m_axis_tready) begin
                got.order = m_axis_tdata[1:0];
                got.too_long = m_axis_tdata[2];
                verdicts_seen++;
                if (verdict_q.size() == 0) begin
                    $error("unexpected result word %b", m_axis_tdata);
                    errors++;
                end else begin
                    exp_v = verdict_q.pop_front();
                    if (got.order !== exp_v.order) begin
                        $error("order: expected %b, got %b", exp_v.order, got.order);
                        errors++;
                    end
                    if (got.too_long !== exp_v.too_long) begin
                        $error("too_long: expected %b, got %b",
                               exp_v.too_long, got.too_long);
                        errors++;
                    end
                end
            end
        end
    end

    typedef struct {
        string    a;
        string    b;
        int       want;   // 2 = use predictor only
        bit       typed_long;
    } pair_row_t;

    pair_row_t pair_table [] = '{
        '{"", "", ORD_EQ, 0},
        '{"1.0", "1.0", ORD_EQ, 0},
        '{"1.0~rc1", "1.0", ORD_LT, 0},
        '{"~", "", ORD_LT, 0},
        '{"0:1.0", "1.0", ORD_EQ, 0},
        '{"000:1", "1", ORD_EQ, 0},
        '{"2:1", "1:9", ORD_GT, 0},
        '{"1.0-1", "1.0-2", ORD_LT, 0},
        '{"1-2-3", "1-2-4", ORD_LT, 0},
        '{"a:1", "a:1", ORD_EQ, 0},
        '{"007", "7", ORD_EQ, 0},
        '{"10", "9", ORD_GT, 0},
        '{"1a", "1.", ORD_LT, 0},
        '{"1+", "1Z", ORD_GT, 0},
        '{":1", "1", 2, 0},
        '{"1.2.3-4ubx", "1.2.3-4ub", 2, 0},
        '{"1:2:3-", "1:2:3", 2, 0}
    };

    initial begin
        char_word_t w;
        clear_strings();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        foreach (pair_table[i]) begin
            if (i % 2) begin
                send_string(1, pair_table[i].b);
                send_string(0, pair_table[i].a);
            end else begin
                send_string(0, pair_table[i].a);
                send_string(1, pair_table[i].b);
            end
            if (pair_table[i].want != 2 && verdict_q.size() != 0 &&
                verdict_q[$].order != 2'(pair_table[i].want)) begin
                $error("order: expected %b, got %b (predictor, row %0d)",
                       2'(pair_table[i].want), verdict_q[$].order, i);
                errors++;
            end
        end
        // zero byte, high byte, a word for a finished string, idle non-last word
        send_word('{0, 8'h00, 1, 0});
        send_word('{0, 8'hFF, 1, 1});
        send_word('{0, 8'h31, 1, 1});
        send_word('{1, 8'h55, 0, 0});
        send_word('{1, 8'h80, 1, 1});
        // overflow on both sides
        for (int k = 0; k < MAX_LEN + 3; k++) send_word('{0, 8'h31, 1, 0});
        send_word('{0, 8'h00, 0, 1});
        for (int k = 0; k < MAX_LEN + 1; k++) send_word('{1, 8'h39, 1, k == MAX_LEN});

        // random part: interleaved well-formed pairs plus noise words
        while (words_sent < 1050) begin
            if (words_sent > 900) quiet = 1'b1;
            if ($urandom_range(0, 7) == 0) begin
                w = 11'($urandom);
                send_word(w);
            end else begin
                string sa, sb;
                int ia, ib;
                sa = rand_version();
                sb = ($urandom_range(0, 3) == 0) ? sa : rand_version();
                ia = 0;
                ib = 0;
                while (ia <= sa.len() || ib <= sb.len()) begin
                    if (ib > sb.len() || (ia <= sa.len() && $urandom_range(0, 1))) begin
                        w = (sa.len() == 0) ? char_word_t'{0, 8'h00, 0, 1}
                          : (ia == sa.len()) ? char_word_t'{0, 8'h00, 0, 1}
                          : char_word_t'{0, sa[ia], 1, 0};
                        if (ia == sa.len() - 1) w.last = 1;
                        if (!(sa.len() != 0 && ia == sa.len())) send_word(w);
                        ia = (w.last) ? sa.len() + 1 : ia + 1;
                    end else begin
                        w = (sb.len() == 0) ? char_word_t'{1, 8'h00, 0, 1}
                          : (ib == sb.len()) ? char_word_t'{1, 8'h00, 0, 1}
                          : char_word_t'{1, sb[ib], 1, 0};
                        if (ib == sb.len() - 1) w.last = 1;
                        if (!(sb.len() != 0 && ib == sb.len())) send_word(w);
                        ib = (w.last) ? sb.len() + 1 : ib + 1;
                    end
                end
            end
        end
        // close any open pair so nothing is left half loaded
        send_word('{0, 8'h00, 0, 1});
        send_word('{1, 8'h00, 0, 1});
        s_axis_tvalid <= 1'b0;

        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (600) @(posedge aclk);
        $display("Sent %0d character words, checked %0d comparison results.",
                 words_sent, verdicts_seen);
        if (errors == 0) begin
            $display("** package_version_comparator_unit: PASSED **");
        end else begin
            $display("** package_version_comparator_unit: FAILED **");
        end
        $finish;
    end

    // hard limit on run time
    initial begin
        #20000000;
        $display("** package_version_comparator_unit: FAILED **");
        $finish;
    end
endmodule
